/* sv/palette_frame_buffer_port_defines.svh */
// Assertion macros shared by the frame buffer RTL
`ifndef PALETTE_FRAME_BUFFER_PORT_DEFINES_SVH
`define PALETTE_FRAME_BUFFER_PORT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfb: check failed");

// Next-cycle implication, checked out of reset
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfb: check failed");

`endif

/* sv/pfb_pkg.sv */
`default_nettype none
package pfb_pkg;

    // Store geometry
    localparam int PIXEL_DEPTH     = 4096;
    localparam int PIX_AW          = $clog2(PIXEL_DEPTH);
    localparam int SCAN_LENGTH     = 3072;
    localparam int SCAN_W          = 12;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int LANES           = 3;
    localparam int LANE_W          = 2;

    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_LENGTH - 1);
    localparam logic [PIX_AW-1:0] CLEAR_LAST = PIX_AW'(PIXEL_DEPTH - 1);
    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

    // Action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Port codes
    localparam logic [7:0] PORT_ADDR   = 8'd2;
    localparam logic [7:0] PORT_PIXEL  = 8'd3;
    localparam logic [7:0] PORT_PAL_IX = 8'd4;
    localparam logic [7:0] PORT_COLOUR = 8'd5;
    localparam logic [7:0] PORT_SCAN   = 8'd6;

    typedef enum logic {
        MODE_CLEAR,
        MODE_RUN
    } t_mode;

    typedef struct packed {
        logic       action;
        logic [7:0] port;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_out_word;

endpackage
`default_nettype wire

/* sv/pfb_in_if.sv */
`default_nettype none
interface pfb_in_if;
    logic              valid;
    logic              ready;
    pfb_pkg::t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

/* sv/pfb_out_if.sv */
`default_nettype none
interface pfb_out_if;
    logic               valid;
    logic               ready;
    pfb_pkg::t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

/* sv/pfb_ram.sv */
`default_nettype none
// Single-port-write, single-port-read RAM with registered read data
module pfb_ram #(
    parameter  int DEPTH = 256,
    parameter  int WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/palette_frame_buffer_port.sv */
// Channel   Dir  Payload                        Handshake
// i_in      in   action, port, data             valid/ready
// o_out     out  red, green, blue, frame_end    valid/ready
//
// One word per cycle in steady state while o_out is not stalled; after acceptance a
// tick's pixel is read from pixel RAM, then palette RAM, into the output register.
// After reset a clearing pass over every pixel address zeroes both stores; i_in.ready
// is low for its length. A stalled output holds the pipeline and i_in.ready.
// Port writes take effect at acceptance; writes during a scan are dropped.
`default_nettype none
`include "palette_frame_buffer_port_defines.svh"
module palette_frame_buffer_port (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfb_in_if.sink     i_in,
    pfb_out_if.source  o_out
);
    import pfb_pkg::*;

    t_mode               r_mode, n_mode;
    logic [PIX_AW-1:0]   r_clr_cnt, n_clr_cnt;
    logic [15:0]         r_vaddr, n_vaddr;
    logic                r_hi_next, n_hi_next;
    logic [PAL_AW-1:0]   r_row, n_row;
    logic [LANE_W-1:0]   r_lane, n_lane;
    logic [SCAN_W-1:0]   r_pos, n_pos;
    logic                r_running, n_running;
    logic                r_s1_vld, r_s1_last;
    logic                r_s2_vld, r_s2_last;

    logic                clr_en;
    logic                run_en;
    logic                adv;
    logic                acc;
    logic                is_tick;
    logic                is_wr;
    logic                scan_tick;
    logic [7:0]          pix_q;
    logic [7:0]          lane_q [LANES];
    t_out_word           out_w;

    // mode: next state
    always_comb begin
        n_mode    = r_mode;
        n_clr_cnt = r_clr_cnt;
        unique case (r_mode)
            MODE_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLEAR_LAST) begin
                    n_mode = MODE_RUN;
                end
            end
            MODE_RUN: begin
                n_mode = MODE_RUN;
            end
            default: begin
                n_mode = MODE_CLEAR;
            end
        endcase
    end

    // mode: outputs
    always_comb begin
        clr_en = 1'b0;
        run_en = 1'b0;
        unique case (r_mode)
            MODE_CLEAR: clr_en = 1'b1;
            MODE_RUN:   run_en = 1'b1;
            default:    clr_en = 1'b1;
        endcase
    end

    // handshake
    assign adv        = !r_s2_vld || o_out.ready;
    assign i_in.ready = run_en && adv;
    assign acc        = i_in.valid && i_in.ready;
    assign is_tick    = acc && (i_in.word.action == ACT_TICK);
    assign is_wr      = acc && (i_in.word.action == ACT_WRITE) && !r_running;
    assign scan_tick  = is_tick && r_running;

    // port decode and scan position
    always_comb begin
        n_vaddr   = r_vaddr;
        n_hi_next = r_hi_next;
        n_row     = r_row;
        n_lane    = r_lane;
        n_pos     = r_pos;
        n_running = r_running;
        if (is_wr) begin
            unique case (i_in.word.port)
                PORT_ADDR: begin
                    if (r_hi_next) begin
                        n_vaddr = {i_in.word.data, r_vaddr[7:0]};
                    end else begin
                        n_vaddr = {r_vaddr[15:8], i_in.word.data};
                    end
                    n_hi_next = !r_hi_next;
                end
                PORT_PIXEL: begin
                    n_hi_next = 1'b1;
                    n_vaddr   = r_vaddr + 16'd1;
                end
                PORT_PAL_IX: begin
                    n_row  = i_in.word.data;
                    n_lane = '0;
                end
                PORT_COLOUR: begin
                    if (r_lane >= LANE_LAST) begin
                        n_lane = '0;
                        n_row  = r_row + 1'b1;
                    end else begin
                        n_lane = r_lane + 1'b1;
                    end
                end
                PORT_SCAN: begin
                    n_pos     = '0;
                    n_running = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (scan_tick) begin
            if (r_pos == SCAN_LAST) begin
                n_pos     = '0;
                n_running = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CLEAR;
            r_clr_cnt <= '0;
            r_vaddr   <= 16'd1;
            r_hi_next <= 1'b1;
            r_row     <= '0;
            r_lane    <= '0;
            r_pos     <= '0;
            r_running <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_clr_cnt <= n_clr_cnt;
            r_vaddr   <= n_vaddr;
            r_hi_next <= n_hi_next;
            r_row     <= n_row;
            r_lane    <= n_lane;
            r_pos     <= n_pos;
            r_running <= n_running;
            if (adv) begin
                r_s1_vld  <= scan_tick;
                r_s1_last <= (r_pos == SCAN_LAST);
                r_s2_vld  <= r_s1_vld;
                r_s2_last <= r_s1_last;
            end
        end
    end

    // pixel store: clear sweep, port writes, scan reads
    pfb_ram #(
        .DEPTH (PIXEL_DEPTH),
        .WIDTH (8)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (clr_en || (is_wr && (i_in.word.port == PORT_PIXEL))),
        .i_waddr (clr_en ? r_clr_cnt : r_vaddr[PIX_AW-1:0]),
        .i_wdata (clr_en ? 8'd0 : i_in.word.data),
        .i_re    (scan_tick),
        .i_raddr (r_pos[PIX_AW-1:0]),
        .o_rdata (pix_q)
    );

    // palette: one byte lane per colour, addressed by palette row
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        pfb_ram #(
            .DEPTH (PALETTE_ENTRIES),
            .WIDTH (8)
        ) u_pal_ram (
            .i_clk   (i_clk),
            .i_we    (clr_en || (is_wr && (i_in.word.port == PORT_COLOUR)
                                   && (r_lane == LANE_W'(l)))),
            .i_waddr (clr_en ? r_clr_cnt[PAL_AW-1:0] : r_row),
            .i_wdata (clr_en ? 8'd0 : i_in.word.data),
            .i_re    (adv && r_s1_vld),
            .i_raddr (pix_q[PAL_AW-1:0]),
            .o_rdata (lane_q[l])
        );
    end

    // output word straight from the palette read registers
    always_comb begin
        out_w.red       = lane_q[0];
        out_w.green     = lane_q[1];
        out_w.blue      = lane_q[2];
        out_w.frame_end = r_s2_last;
    end

    assign o_out.valid = r_s2_vld;
    assign o_out.word  = out_w;

    // checks
    `PFB_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, clr_en, !i_in.ready)
    `PFB_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, r_s1_vld && adv, o_out.valid)
    `PFB_ASSERT_NEXT(a_last_stops_scan, i_clk, i_rst_n,
                     scan_tick && (r_pos == SCAN_LAST), !r_running && r_s1_last)
    `PFB_ASSERT_NEXT(a_pixel_wr_hi, i_clk, i_rst_n,
                     is_wr && (i_in.word.port == PORT_PIXEL), r_hi_next)
    `PFB_ASSERT_NOW(a_lane_range, i_clk, i_rst_n, 1'b1, r_lane <= LANE_LAST)

endmodule
`default_nettype wire

/* verif/tb_palette_frame_buffer_port.sv */
`timescale 1ns / 1ps
module tb_palette_frame_buffer_port;
    import pfb_pkg::*;

    localparam int COLOUR_BYTES = PALETTE_ENTRIES * LANES;
    localparam int STALL_LIMIT  = 12000;  // covers the clearing pass
    localparam int CALM_TAIL    = 500;
    localparam int SETUP_BLOCKS = 25;
    localparam int SCAN_BLOCK   = 150;

    logic i_clk;
    logic i_rst_n;

    pfb_in_if  in_if ();
    pfb_out_if out_if ();

    palette_frame_buffer_port u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Words waiting to be driven, pixels waiting to come out
    t_in_word  port_words [$];
    t_out_word pixel_due [$];

    // Shadow of the frame buffer
    logic [7:0]        pix_mem [PIXEL_DEPTH];
    logic [7:0]        pal_mem [COLOUR_BYTES];
    logic [15:0]       vaddr;
    logic              hi_next;
    logic [9:0]        pal_ptr;
    logic [SCAN_W-1:0] scan_pos;
    logic              scanning;

    // Run statistics
    int  mismatches;
    int  words_in;
    int  pixels_seen;
    int  frames_seen;
    int  dropped_writes;
    int  quiet_cycles;
    int  in_gap;
    int  out_stall;
    int  gen_ticks_left;  // ticks the stimulus still owes to the scan it started
    bit  tail_phase;
    logic in_taken;

    function automatic bit quiet_tail();
        return tail_phase && port_words.size() < CALM_TAIL;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_model();
        foreach (pix_mem[i]) pix_mem[i] = '0;
        foreach (pal_mem[i]) pal_mem[i] = '0;
        vaddr    = 16'd1;
        hi_next  = 1'b1;
        pal_ptr  = '0;
        scan_pos = '0;
        scanning = 1'b0;
    endtask

    // Apply one accepted word to the shadow; a tick mid-scan yields one pixel
    task automatic frame_buffer_step(input t_in_word w);
        t_out_word  px;
        logic [9:0] base;
        if (w.action == ACT_WRITE && scanning) begin
            dropped_writes++;
        end else if (w.action == ACT_WRITE) begin
            case (w.port)
                PORT_ADDR: begin
                    if (hi_next) vaddr[15:8] = w.data;
                    else vaddr[7:0] = w.data;
                    hi_next = ~hi_next;
                end
                PORT_PIXEL: begin
                    hi_next = 1'b1;
                    pix_mem[vaddr[PIX_AW-1:0]] = w.data;
                    vaddr = vaddr + 16'd1;
                end
                PORT_PAL_IX: pal_ptr = 10'(int'(w.data) * LANES);
                PORT_COLOUR: begin
                    if (pal_ptr < COLOUR_BYTES) begin
                        pal_mem[pal_ptr] = w.data;
                        pal_ptr = (pal_ptr == COLOUR_BYTES - 1) ? '0 : pal_ptr + 10'd1;
                    end else begin
                        pal_ptr = '0;
                    end
                end
                PORT_SCAN: begin
                    scan_pos = '0;
                    scanning = 1'b1;
                end
                default: ;
            endcase
        end else if (scanning) begin
            base         = 10'(int'(pix_mem[scan_pos]) * LANES);
            px.red       = pal_mem[base];
            px.green     = pal_mem[base + 10'd1];
            px.blue      = pal_mem[base + 10'd2];
            px.frame_end = (scan_pos == SCAN_LAST);
            pixel_due.push_back(px);
            if (px.frame_end) begin
                scanning = 1'b0;
                scan_pos = '0;
            end else begin
                scan_pos = scan_pos + 1'b1;
            end
        end
    endtask

    // Compare an output word against the oldest predicted pixel
    task automatic check_pixel(input t_out_word got);
        t_out_word want;
        if (pixel_due.size() == 0) begin
            $display("%0t: unexpected pixel r=%0h g=%0h b=%0h end=%0b", $time,
                     got.red, got.green, got.blue, got.frame_end);
            mismatches++;
        end else begin
            want = pixel_due.pop_front();
            pixels_seen++;
            if (got.frame_end) frames_seen++;
            if (got.red !== want.red) begin
                $display("%0t: red expected %0h got %0h", $time, want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %0h got %0h", $time, want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %0h got %0h", $time, want.blue, got.blue);
                mismatches++;
            end
            if (got.frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b got %0b", $time,
                         want.frame_end, got.frame_end);
                mismatches++;
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) check_pixel(out_if.word);
            if (in_if.valid && in_if.ready) begin
                words_in++;
                frame_buffer_step(in_if.word);
            end
        end
    end

    // Driver: next word after acceptance, with short random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_if.valid <= 1'b0;
            end else if (port_words.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 2);
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid <= 1'b1;
                in_if.word  <= port_words.pop_front();
            end
        end
    end

    // Receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            out_if.ready <= 1'b0;
        end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
            out_stall = $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus helpers
    task automatic queue_word(input logic act, input logic [7:0] prt, input logic [7:0] dat);
        t_in_word w;
        w.action = act;
        w.port   = prt;
        w.data   = dat;
        port_words.push_back(w);
        if (gen_ticks_left == 0) begin
            if (act == ACT_WRITE && prt == PORT_SCAN) gen_ticks_left = SCAN_LENGTH;
        end else if (act == ACT_TICK) begin
            gen_ticks_left--;
        end
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly small values so pixels land on palette entries that get written
    function automatic logic [7:0] low_byte();
        return ($urandom_range(0, 3) == 0) ? any_byte() : 8'($urandom_range(0, 15));
    endfunction

    // A run of ticks into the scan, with stray writes that must be dropped
    task automatic scan_ticks(input int n);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) queue_word(ACT_WRITE, any_byte(), any_byte());
            else queue_word(ACT_TICK, any_byte(), any_byte());
        end
    endtask

    // Address loads, pixel runs and palette fills with some noise
    task automatic program_frame(input int blocks);
        logic [7:0] prt;
        repeat (blocks) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    queue_word(ACT_WRITE, PORT_ADDR, low_byte());
                    // occasionally only the high byte, leaving the select half-way
                    if ($urandom_range(0, 7) != 0) queue_word(ACT_WRITE, PORT_ADDR, any_byte());
                    repeat ($urandom_range(1, 24)) queue_word(ACT_WRITE, PORT_PIXEL, low_byte());
                end
                4, 5, 6: begin
                    queue_word(ACT_WRITE, PORT_PAL_IX, low_byte());
                    repeat ($urandom_range(1, 12)) queue_word(ACT_WRITE, PORT_COLOUR, any_byte());
                end
                7: begin
                    prt = any_byte();
                    if (prt >= PORT_ADDR && prt <= PORT_SCAN) prt = prt + 8'd5;
                    if ($urandom_range(0, 1) == 0) queue_word(ACT_WRITE, prt, any_byte());
                    else queue_word(ACT_TICK, any_byte(), any_byte());
                end
                default: begin
                    repeat ($urandom_range(1, 16)) queue_word(ACT_WRITE, PORT_PIXEL, low_byte());
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (port_words.size() != 0 || in_if.valid || pixel_due.size() != 0);
    endtask

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.word   = '0;
        out_if.ready = 1'b0;

        // Directed: idle tick, undecoded ports, address wrap, palette wrap
        queue_word(ACT_TICK,  8'hFF,       8'hFF);
        queue_word(ACT_WRITE, 8'h00,       8'h00);
        queue_word(ACT_WRITE, 8'h01,       8'hFF);
        queue_word(ACT_WRITE, 8'h07,       8'h55);
        queue_word(ACT_WRITE, 8'hFF,       8'hAA);
        queue_word(ACT_WRITE, PORT_PIXEL,  8'hFF);
        queue_word(ACT_WRITE, PORT_ADDR,   8'hFF);
        queue_word(ACT_WRITE, PORT_ADDR,   8'hFF);
        queue_word(ACT_WRITE, PORT_PIXEL,  8'h01);  // top of store, address wraps to 0
        queue_word(ACT_WRITE, PORT_PIXEL,  8'hFF);
        queue_word(ACT_WRITE, PORT_ADDR,   8'h00);  // high byte only
        queue_word(ACT_WRITE, PORT_PIXEL,  8'h02);  // select back to high
        queue_word(ACT_WRITE, PORT_PAL_IX, 8'hFF);
        queue_word(ACT_WRITE, PORT_COLOUR, 8'hFF);
        queue_word(ACT_WRITE, PORT_COLOUR, 8'h00);
        queue_word(ACT_WRITE, PORT_COLOUR, 8'hA5);  // pointer wraps to 0
        queue_word(ACT_WRITE, PORT_COLOUR, 8'h5A);
        queue_word(ACT_WRITE, PORT_PAL_IX, 8'h02);
        queue_word(ACT_WRITE, PORT_COLOUR, 8'h12);
        queue_word(ACT_WRITE, PORT_COLOUR, 8'h34);
        queue_word(ACT_WRITE, PORT_COLOUR, 8'h56);

        // Random frames
        program_frame(SETUP_BLOCKS);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        program_frame(SETUP_BLOCKS);

        // Start the scan, with writes that must be dropped while it runs
        queue_word(ACT_WRITE, PORT_SCAN,   8'h00);
        queue_word(ACT_TICK,  8'h00,       8'h00);
        queue_word(ACT_WRITE, PORT_ADDR,   8'h3C);  // dropped mid-scan
        queue_word(ACT_WRITE, PORT_SCAN,   8'hFF);  // dropped mid-scan
        scan_ticks(SCAN_BLOCK);

        // Sender holds off until every pixel so far is out
        wait_drained();
        tail_phase = 1'b1;
        scan_ticks(SCAN_BLOCK);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d words, %0d pixels checked, %0d frames, %0d writes dropped",
                 words_in, pixels_seen, frames_seen, dropped_writes);
        $display("summary: palette and address wrap, idle ticks, undecoded ports, part of a scan");
        if (mismatches == 0 && pixel_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
